// ===== rtl/mfs_pkg.sv =====
package mfs_pkg;

    // Field widths of the input and result words.
    localparam int ID_W     = 14;
    localparam int RATING_W = 3;
    localparam int Q_W      = 16;
    localparam int ERR_W    = 17;
    localparam int LR_W     = 16;
    localparam int MAP_W    = $clog2(ID_W);

    // Default table shape.
    localparam int DEF_USER_ROWS  = 16384;
    localparam int DEF_MOVIE_ROWS = 16384;
    localparam int DEF_FEATURES   = 5;

    // Reset values: 0.1 in Q3.12 and a learning rate of about 0.001 in Q0.16.
    localparam logic signed [Q_W-1:0] FACTOR_INIT = 16'sd410;
    localparam logic [LR_W-1:0]       LR_RESET    = 16'd66;

    // Command codes.
    localparam logic CMD_TRAIN   = 1'b0;
    localparam logic CMD_PREDICT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_BASE,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_PRED,
        S_SCALE,
        S_SCALE_ST,
        S_UP_RD,
        S_UP_MU,
        S_UP_MM,
        S_UP_WR,
        S_DONE
    } state_t;

endpackage

// ===== rtl/matrix_factorization_sgd.sv =====
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-----------------------------------------
// in      | into      | in_valid / in_stall  | cmd, user_id, movie_id, rating
// out     | out of    | out_valid / out_stall| predicted, rating_error
// cfg     | into      | cfg_we               | cfg_wdata (learning rate, Q0.16)
//
// A predict word maps both ids to rows, sums the dot product and rounds it;
// a train word then also scales the error and updates both factor rows. The
// sequencer drives one shared multiplier and one read port per factor table,
// and each table update is a read-modify-write. The row remainders come from
// a constant reciprocal multiply and a correcting subtract. After reset both
// tables are swept to 0.1, one entry per cycle; no word is taken until then.
// A finished result sits in the output register, so the next word can be taken
// in the following cycle while the result waits; a new result is only loaded
// once that slot is free.
module matrix_factorization_sgd
    import mfs_pkg::*;
#(
    parameter int USER_ROWS  = DEF_USER_ROWS,
    parameter int MOVIE_ROWS = DEF_MOVIE_ROWS,
    parameter int FEATURES   = DEF_FEATURES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [LR_W-1:0]          cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic [ID_W-1:0]          user_id,
    input  logic [ID_W-1:0]          movie_id,
    input  logic [RATING_W-1:0]      rating,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [Q_W-1:0]    predicted,
    output logic signed [ERR_W-1:0]  rating_error
);

    // Table geometry: entry address is row * FEATURES + feature.
    localparam int U_ENTRIES   = USER_ROWS * FEATURES;
    localparam int M_ENTRIES   = MOVIE_ROWS * FEATURES;
    localparam int AU_W        = $clog2(U_ENTRIES);
    localparam int AM_W        = $clog2(M_ENTRIES);
    localparam int RU_W        = $clog2(USER_ROWS);
    localparam int RM_W        = $clog2(MOVIE_ROWS);
    localparam int CLR_ENTRIES = (U_ENTRIES > M_ENTRIES) ? U_ENTRIES : M_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_ENTRIES);
    localparam int FC_W        = $clog2(FEATURES + 1);

    // Reciprocals of the row counts, scaled by 2^ID_W and rounded down. The
    // quotient estimate they give is the true quotient or one less.
    localparam int U_RECIP = (1 << ID_W) / USER_ROWS;
    localparam int M_RECIP = (1 << ID_W) / MOVIE_ROWS;

    // Shared multiplier: a 33-bit signed operand times a 17-bit signed one.
    localparam int MA_W   = 33;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    // The exact dot product: each term fits 32 bits, the sum grows by log2(FEATURES).
    localparam int ACC_W  = 33 + $clog2(FEATURES);
    localparam int SH_W   = ACC_W - 12;
    // Update path: the delta after the shift by 28 and the widened new value.
    localparam int DL_W   = PROD_W - 28;
    localparam int NV_W   = DL_W + 1;

    localparam logic signed [PROD_W-1:0] UPD_HALF = 50'sd134217728;

    // Storage for both factor tables.
    logic signed [Q_W-1:0] umem [U_ENTRIES];
    logic signed [Q_W-1:0] mmem [M_ENTRIES];

    state_t state_reg, state_next;

    logic                     out_valid_reg, out_valid_next;
    logic [LR_W-1:0]          lr_reg;
    logic [CLR_W-1:0]         clr_reg, clr_next;

    logic                     cmd_reg, cmd_next;
    logic [ID_W-1:0]          uid_reg, uid_next;
    logic [ID_W-1:0]          mid_reg, mid_next;
    logic [RATING_W-1:0]      rating_reg, rating_next;
    logic [MAP_W-1:0]         map_reg, map_next;
    logic [ID_W-1:0]          uq_reg, uq_next;
    logic [ID_W-1:0]          mq_reg, mq_next;
    logic [RU_W-1:0]          ur_reg, ur_next;
    logic [RM_W-1:0]          mr_reg, mr_next;
    logic [AU_W-1:0]          ubase_reg, ubase_next;
    logic [AM_W-1:0]          mbase_reg, mbase_next;
    logic [FC_W-1:0]          feat_reg, feat_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MA_W-1:0]   scaled_reg, scaled_next;
    logic signed [Q_W-1:0]    pred_reg, pred_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [Q_W-1:0]    new_u_reg, new_u_next;
    logic signed [Q_W-1:0]    predicted_reg, predicted_next;
    logic signed [ERR_W-1:0]  rating_error_reg, rating_error_next;

    logic signed [Q_W-1:0]    u_rd_reg;
    logic signed [Q_W-1:0]    m_rd_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;

    logic                     u_we, m_we;
    logic [AU_W-1:0]          u_addr, u_waddr;
    logic [AM_W-1:0]          m_addr, m_waddr;
    logic signed [Q_W-1:0]    u_wdata, m_wdata;

    logic [2*ID_W-1:0]        uq_prod, mq_prod;
    logic [ID_W-1:0]          u_back, m_back;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [PROD_W-1:0] upd_rnd;
    logic signed [DL_W-1:0]   delta;
    logic signed [Q_W-1:0]    upd_old;
    logic signed [Q_W-1:0]    upd_new;
    logic                     feat_last;

    // Saturate a widened update result to Q3.12.
    function automatic logic signed [Q_W-1:0] sat_upd(input logic signed [NV_W-1:0] x);
        logic ovf;
        ovf = (x[NV_W-1:Q_W-1] != {(NV_W-Q_W+1){x[NV_W-1]}});
        if (ovf)
        begin
            return x[NV_W-1] ? 16'sh8000 : 16'sh7fff;
        end
        return x[Q_W-1:0];
    endfunction

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign predicted    = predicted_reg;
    assign rating_error = rating_error_reg;

    assign u_addr    = ubase_reg + AU_W'(feat_reg);
    assign m_addr    = mbase_reg + AM_W'(feat_reg);
    assign feat_last = (feat_reg == FC_W'(FEATURES - 1));

    // Row remainder: the quotient estimate from the reciprocal, and its
    // product with the row count, which never exceeds the id itself.
    assign uq_prod = (2*ID_W)'(uid_reg) * (2*ID_W)'(U_RECIP);
    assign mq_prod = (2*ID_W)'(mid_reg) * (2*ID_W)'(M_RECIP);
    assign u_back  = ID_W'((2*ID_W)'(uq_reg) * (2*ID_W)'(USER_ROWS));
    assign m_back  = ID_W'((2*ID_W)'(mq_reg) * (2*ID_W)'(MOVIE_ROWS));

    // Rounded product of the update path, shared by the user and movie halves.
    assign upd_rnd = prod_reg + UPD_HALF;
    assign delta   = upd_rnd[PROD_W-1:28];
    assign upd_old = (state_reg == S_UP_WR) ? m_rd_reg : u_rd_reg;
    assign upd_new = sat_upd(NV_W'(upd_old) + NV_W'(delta));

    // Prediction rounding: add one half and keep the upper bits (floor).
    assign acc_rnd = acc_reg + ACC_W'(2048);
    assign acc_sh  = acc_rnd[ACC_W-1:12];

    // The one multiplier of the block.
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lr_reg        <= LR_RESET;
            clr_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            if (cfg_we)
            begin
                lr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        uid_reg          <= uid_next;
        mid_reg          <= mid_next;
        rating_reg       <= rating_next;
        map_reg          <= map_next;
        uq_reg           <= uq_next;
        mq_reg           <= mq_next;
        ur_reg           <= ur_next;
        mr_reg           <= mr_next;
        ubase_reg        <= ubase_next;
        mbase_reg        <= mbase_next;
        feat_reg         <= feat_next;
        acc_reg          <= acc_next;
        prod_reg         <= prod_next;
        scaled_reg       <= scaled_next;
        pred_reg         <= pred_next;
        err_reg          <= err_next;
        new_u_reg        <= new_u_next;
        predicted_reg    <= predicted_next;
        rating_error_reg <= rating_error_next;
    end

    // Factor tables: one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (u_we)
        begin
            umem[u_waddr] <= u_wdata;
        end
        u_rd_reg <= umem[u_addr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mmem[m_waddr] <= m_wdata;
        end
        m_rd_reg <= mmem[m_addr];
    end

    always_comb
    begin
        logic acc_ovf;

        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        clr_next          = clr_reg;
        cmd_next          = cmd_reg;
        uid_next          = uid_reg;
        mid_next          = mid_reg;
        rating_next       = rating_reg;
        map_next          = map_reg;
        uq_next           = uq_reg;
        mq_next           = mq_reg;
        ur_next           = ur_reg;
        mr_next           = mr_reg;
        ubase_next        = ubase_reg;
        mbase_next        = mbase_reg;
        feat_next         = feat_reg;
        acc_next          = acc_reg;
        scaled_next       = scaled_reg;
        pred_next         = pred_reg;
        err_next          = err_reg;
        new_u_next        = new_u_reg;
        predicted_next    = predicted_reg;
        rating_error_next = rating_error_reg;

        mul_a   = '0;
        mul_b   = '0;
        u_we    = 1'b0;
        m_we    = 1'b0;
        u_waddr = u_addr;
        m_waddr = m_addr;
        u_wdata = upd_new;
        m_wdata = upd_new;

        acc_ovf = (acc_sh[SH_W-1:Q_W-1] != {(SH_W-Q_W+1){acc_sh[SH_W-1]}});

        // The waiting result leaves when the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                u_waddr = clr_reg[AU_W-1:0];
                m_waddr = clr_reg[AM_W-1:0];
                u_wdata = FACTOR_INIT;
                m_wdata = FACTOR_INIT;
                u_we    = ({1'b0, clr_reg} < (CLR_W+1)'(U_ENTRIES));
                m_we    = ({1'b0, clr_reg} < (CLR_W+1)'(M_ENTRIES));
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    uid_next    = user_id;
                    mid_next    = movie_id;
                    rating_next = rating;
                    ur_next     = '0;
                    mr_next     = '0;
                    map_next    = '0;
                    state_next  = S_MAP;
                end
            end

            // Three steps: estimate the quotient, subtract its multiple of the
            // row count, then one correcting subtract if the estimate was short.
            S_MAP:
            begin
                map_next = map_reg + 1'b1;
                if (map_reg == MAP_W'(0))
                begin
                    uq_next = uq_prod[2*ID_W-1:ID_W];
                    mq_next = mq_prod[2*ID_W-1:ID_W];
                end
                else if (map_reg == MAP_W'(1))
                begin
                    uid_next = uid_reg - u_back;
                    mid_next = mid_reg - m_back;
                end
                else
                begin
                    if (int'(uid_reg) >= USER_ROWS)
                    begin
                        ur_next = RU_W'(uid_reg - ID_W'(USER_ROWS));
                    end
                    else
                    begin
                        ur_next = RU_W'(uid_reg);
                    end
                    if (int'(mid_reg) >= MOVIE_ROWS)
                    begin
                        mr_next = RM_W'(mid_reg - ID_W'(MOVIE_ROWS));
                    end
                    else
                    begin
                        mr_next = RM_W'(mid_reg);
                    end
                    state_next = S_BASE;
                end
            end

            S_BASE:
            begin
                ubase_next = AU_W'(ur_reg) * AU_W'(FEATURES);
                mbase_next = AM_W'(mr_reg) * AM_W'(FEATURES);
                feat_next  = '0;
                acc_next   = '0;
                state_next = S_MAC_RD;
            end

            S_MAC_RD:
            begin
                state_next = S_MAC_MUL;
            end

            S_MAC_MUL:
            begin
                mul_a      = MA_W'(u_rd_reg);
                mul_b      = MB_W'(m_rd_reg);
                state_next = S_MAC_ACC;
            end

            S_MAC_ACC:
            begin
                acc_next = acc_reg + prod_reg[ACC_W-1:0];
                if (feat_last)
                begin
                    state_next = S_PRED;
                end
                else
                begin
                    feat_next  = feat_reg + 1'b1;
                    state_next = S_MAC_RD;
                end
            end

            S_PRED:
            begin
                if (acc_ovf)
                begin
                    pred_next = acc_sh[SH_W-1] ? 16'sh8000 : 16'sh7fff;
                end
                else
                begin
                    pred_next = acc_sh[Q_W-1:0];
                end
                if (cmd_reg == CMD_PREDICT)
                begin
                    err_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    err_next   = {2'b00, rating_reg, 12'h000} - ERR_W'(pred_next);
                    state_next = S_SCALE;
                end
            end

            S_SCALE:
            begin
                mul_a      = MA_W'(lr_reg);
                mul_b      = err_reg;
                state_next = S_SCALE_ST;
            end

            S_SCALE_ST:
            begin
                scaled_next = prod_reg[MA_W-1:0];
                feat_next   = '0;
                state_next  = S_UP_RD;
            end

            S_UP_RD:
            begin
                state_next = S_UP_MU;
            end

            S_UP_MU:
            begin
                mul_a      = scaled_reg;
                mul_b      = MB_W'(m_rd_reg);
                state_next = S_UP_MM;
            end

            S_UP_MM:
            begin
                // The user value moves by the movie product; the movie product
                // then uses the user value from before this write.
                new_u_next = upd_new;
                mul_a      = scaled_reg;
                mul_b      = MB_W'(u_rd_reg);
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                u_we    = 1'b1;
                m_we    = 1'b1;
                u_wdata = new_u_reg;
                m_wdata = upd_new;
                if (feat_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    feat_next  = feat_reg + 1'b1;
                    state_next = S_UP_RD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    predicted_next    = pred_reg;
                    rating_error_next = err_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mfs_chk.sv =====
module mfs_chk
    import mfs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [Q_W-1:0]    predicted,
    input logic signed [ERR_W-1:0]  rating_error
);

    // A word that has just been taken keeps the input closed while it is worked on.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input taken again straight after an accepted word");

    // A new result only appears at the end of a word's work, never while idle.
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared without a word in progress");

    // A stalled result stays and does not change.
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(predicted) && $stable(rating_error))
    ) else $error("stalled result dropped or changed");

endmodule

bind matrix_factorization_sgd mfs_chk u_mfs_chk (.*);
